// ===== rtl/ogdi_pkg.sv =====
// Shared constants, codes and the disc half-width table for the grid inflation block.
package ogdi_pkg;

   localparam int DEF_GRID_ROWS = 64;
   localparam int DEF_GRID_COLS = 64;

   localparam int ROW_W       = 6;
   localparam int COL_W       = 6;
   localparam int OCC_W       = 8;
   localparam int RAD_W       = 4;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 8;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   // signed row arithmetic, wide enough for any grid height plus the radius
   localparam int SPAN_W = 12;
   // column compares: col + half width stays below 256
   localparam int CMP_W  = 8;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS    = 1'b1;

   localparam logic [OCC_W-1:0] THRESHOLD_RESET = 8'd77;
   localparam logic [RAD_W-1:0] RADIUS_RESET    = 4'd4;

   // entry {radius, |dr|} holds floor(sqrt(radius^2 - dr^2)), 4 bits each
   function automatic logic [1023:0] build_half_width();
      logic [1023:0] t;
      int            h;
      t = '0;
      for (int r = 0; r < 16; r++) begin
         for (int d = 0; d < 16; d++) begin
            h = 0;
            if (d <= r) begin
               while ((h + 1) * (h + 1) <= r * r - d * d) begin
                  h++;
               end
            end
            t[(r * 16 + d) * 4 +: 4] = 4'(h);
         end
      end
      return t;
   endfunction

   localparam logic [1023:0] HALF_WIDTH_TABLE = build_half_width();

   function automatic logic [RAD_W-1:0] half_width(input logic [RAD_W-1:0] radius,
                                                   input logic [RAD_W-1:0] abs_dr);
      logic [9:0] base;
      base = {radius, abs_dr, 2'b00};
      return HALF_WIDTH_TABLE[base +: 4];
   endfunction

endpackage

// ===== rtl/occupancy_grid_disc_inflation.sv =====
// Occupancy grid with disc inflation: row-word memory and query sequencer.
//
//  channel | direction | payload
//  req     | in        | tuser: opcode; tdata: row, col, occupancy
//  rsp     | out       | tdata: inflated, occupied
//  csr     | in        | index 0 threshold, index 1 radius
//
// A load inside the grid reads the row word, then writes it back.
// A query steps through the accept, one memory read per disc row inside the grid,
// the evaluation and the result; the single read port gives each disc row its own read.
// Reset clears control state and CSR registers only; the grid is not cleared,
// so load a cell before querying it. A result waits in the output register while the
// next request is accepted; a query ending on a full output register waits.
module occupancy_grid_disc_inflation
   import ogdi_pkg::*;
#(
   parameter int GRID_ROWS = DEF_GRID_ROWS,
   parameter int GRID_COLS = DEF_GRID_COLS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // row[5:0], col[11:6], occupancy[19:12]
   input  logic                   req_tuser,   // opcode
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // inflated[0], occupied[1]
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int ROW_AW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
   localparam int COL_AW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_LOAD_WR = 3'd1;
   localparam logic [2:0] ST_QUERY   = 3'd2;
   localparam logic [2:0] ST_DRAIN   = 3'd3;
   localparam logic [2:0] ST_DONE    = 3'd4;

   // row memory: bit c of word r is the occupied bit of cell (r, c)
   logic [GRID_COLS-1:0] mem [0:GRID_ROWS-1];
   logic                 rd_en;
   logic [ROW_AW-1:0]    rd_addr;
   logic [GRID_COLS-1:0] rd_data_ff;
   logic                 wr_en;
   logic [GRID_COLS-1:0] wr_data;

   logic [2:0]       state_ff, state_in;
   logic [OCC_W-1:0] thresh_ff, thresh_in;
   logic [RAD_W-1:0] radius_ff, radius_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             bit_ff, bit_in;
   logic [4:0]       dr_ff, dr_in;
   logic             p_valid_ff, p_valid_in;
   logic             p_self_ff, p_self_in;
   logic [RAD_W-1:0] p_h_ff, p_h_in;
   logic             hit_ff, hit_in;
   logic             self_ff, self_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_inflated_ff, rsp_inflated_in;
   logic             rsp_occupied_ff, rsp_occupied_in;

   logic             accept;
   logic [ROW_W-1:0] req_row;
   logic [COL_W-1:0] req_col;
   logic [OCC_W-1:0] req_occ;
   logic             req_inside;
   logic [SPAN_W-1:0] r0;
   logic             r0_valid;
   logic [4:0]       neg_dr;
   logic [RAD_W-1:0] abs_dr;
   logic [GRID_COLS-1:0] span;
   logic [CMP_W-1:0] col_cmp, h_cmp;

   assign req_row = req_tdata[5:0];
   assign req_col = req_tdata[11:6];
   assign req_occ = req_tdata[19:12];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign req_inside = (SPAN_W'(req_row) < SPAN_W'(GRID_ROWS)) &&
                       (CMP_W'(req_col) < CMP_W'(GRID_COLS));

   assign r0       = SPAN_W'(row_ff) + {{(SPAN_W-5){dr_ff[4]}}, dr_ff};
   assign r0_valid = !r0[SPAN_W-1] && (r0 < SPAN_W'(GRID_ROWS));
   assign neg_dr   = -dr_ff;
   assign abs_dr   = dr_ff[4] ? neg_dr[RAD_W-1:0] : dr_ff[RAD_W-1:0];

   // columns within half width h of the queried column, clipped by the word itself
   assign col_cmp = CMP_W'(col_ff);
   assign h_cmp   = CMP_W'(p_h_ff);
   always_comb begin
      for (int c = 0; c < GRID_COLS; c++) begin
         span[c] = (CMP_W'(c) + h_cmp >= col_cmp) && (CMP_W'(c) <= col_cmp + h_cmp);
      end
   end

   always_comb begin
      wr_data = rd_data_ff;
      wr_data[col_ff[COL_AW-1:0]] = bit_ff;
   end

   always_comb begin
      state_in        = state_ff;
      thresh_in       = thresh_ff;
      radius_in       = radius_ff;
      row_in          = row_ff;
      col_in          = col_ff;
      bit_in          = bit_ff;
      dr_in           = dr_ff;
      p_valid_in      = 1'b0;
      p_self_in       = (dr_ff == 5'd0);
      p_h_in          = half_width(radius_ff, abs_dr);
      hit_in          = hit_ff | (p_valid_ff && (|(rd_data_ff & span)));
      self_in         = (p_valid_ff && p_self_ff) ? rd_data_ff[col_ff[COL_AW-1:0]] : self_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_inflated_in = rsp_inflated_ff;
      rsp_occupied_in = rsp_occupied_ff;
      rd_en           = 1'b0;
      rd_addr         = r0[ROW_AW-1:0];
      wr_en           = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_THRESHOLD: thresh_in = csr_wdata;
            CSR_RADIUS:    radius_in = csr_wdata[RAD_W-1:0];
            default:       ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               row_in  = req_row;
               col_in  = req_col;
               bit_in  = (req_occ > thresh_ff);
               dr_in   = -{1'b0, radius_ff};
               hit_in  = 1'b0;
               self_in = 1'b0;
               if (req_tuser == OP_LOAD) begin
                  // drop loads outside the grid
                  if (req_inside) begin
                     rd_en    = 1'b1;
                     rd_addr  = ROW_AW'(req_row);
                     state_in = ST_LOAD_WR;
                  end
               end else begin
                  state_in = req_inside ? ST_QUERY : ST_DONE;
               end
            end
         end
         ST_LOAD_WR: begin
            // one request in flight, so the read-back cannot race another write
            wr_en    = 1'b1;
            state_in = ST_IDLE;
         end
         ST_QUERY: begin
            rd_en      = r0_valid;
            p_valid_in = r0_valid;
            dr_in      = dr_ff + 5'd1;
            if (dr_ff == {1'b0, radius_ff}) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in    = 1'b1;
               rsp_inflated_in = hit_ff;
               rsp_occupied_in = self_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[row_ff[ROW_AW-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thresh_ff    <= THRESHOLD_RESET;
         radius_ff    <= RADIUS_RESET;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thresh_ff    <= thresh_in;
         radius_ff    <= radius_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff          <= row_in;
      col_ff          <= col_in;
      bit_ff          <= bit_in;
      dr_ff           <= dr_in;
      p_self_ff       <= p_self_in;
      p_h_ff          <= p_h_in;
      hit_ff          <= hit_in;
      self_ff         <= self_in;
      rsp_inflated_ff <= rsp_inflated_in;
      rsp_occupied_ff <= rsp_occupied_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-2){1'b0}}, rsp_occupied_ff, rsp_inflated_ff};

endmodule

// ===== rtl/ogdi_checker.sv =====
// Port-level checks for the grid inflation block, bound to its top level.
module ogdi_checker
   import ogdi_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_DATA_W-1:0]  rsp_tdata
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // a query leaves the sequencer busy in the cycle after its acceptance
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_QUERY) |=> !req_tready)
      else $error("request taken right after a query");

   // a load never produces a response
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_LOAD) && !rsp_tvalid |=> !rsp_tvalid)
      else $error("response appeared after a load");

   // reset leaves the block empty and ready
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

endmodule

bind occupancy_grid_disc_inflation ogdi_checker u_ogdi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
